FILE: rtl/pcrr_pkg.sv
// Package for the per-class round-robin dispatcher: field widths, codes,
// configuration defaults, state and pool types and the group index helper.
// No dependencies.
package pcrr_pkg;

    localparam int WORKER_W = 10;
    localparam int PEND_W   = 16;
    localparam int CNT_W    = 8;
    localparam int SCHED_W  = 3;
    localparam int OP_W     = 3;
    localparam int GRP_W    = 2;
    localparam int HINT_W   = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    // Internal index arithmetic; large enough for any legal group layout.
    localparam int TID_W    = 16;

    localparam int DEF_MAX_GROUPS  = 4;
    localparam int DEF_MAX_WORKERS = 1024;

    localparam logic [CNT_W-1:0]   RST_STAT  = 8'd32;
    localparam logic [CNT_W-1:0]   RST_GET   = 8'd80;
    localparam logic [CNT_W-1:0]   RST_PUT   = 8'd10;
    localparam logic [CNT_W-1:0]   RST_VAL   = 8'd8;
    localparam logic [CNT_W-1:0]   RST_UPD   = 8'd8;
    localparam logic [SCHED_W-1:0] RST_SCHED = 3'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STAT  = 3'd0,
        CFG_GET   = 3'd1,
        CFG_PUT   = 3'd2,
        CFG_VAL   = 3'd3,
        CFG_UPD   = 3'd4,
        CFG_SCHED = 3'd5
    } t_cfg_reg;

    typedef enum logic [OP_W-1:0] {
        OP_READ     = 3'd0,
        OP_WRITE    = 3'd1,
        OP_STAT     = 3'd2,
        OP_DELETE   = 3'd3,
        OP_UPDATE   = 3'd4,
        OP_VALIDATE = 3'd5
    } t_op;

    typedef enum logic {
        CMD_DISPATCH = 1'b0,
        CMD_DONE     = 1'b1
    } t_cmd;

    localparam int NUM_POOLS = 5;

    typedef enum logic [2:0] {
        POOL_STAT = 3'd0,
        POOL_GET  = 3'd1,
        POOL_PUT  = 3'd2,
        POOL_VAL  = 3'd3,
        POOL_UPD  = 3'd4
    } t_pool;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_ADDR,
        ST_READ,
        ST_WB
    } t_state;

    typedef struct packed {
        logic [CNT_W-1:0]   stat_workers;
        logic [CNT_W-1:0]   get_workers;
        logic [CNT_W-1:0]   put_workers;
        logic [CNT_W-1:0]   validate_workers;
        logic [CNT_W-1:0]   update_workers;
        logic [SCHED_W-1:0] scheduler_count;
    } t_cfg;

    typedef struct packed {
        logic  adv;
        t_pool pool;
    } t_ptr_ctl;

    // Group modulo the pointer table depth by repeated subtraction.
    function automatic logic [GRP_W-1:0] grp_index(input logic [GRP_W-1:0] grp,
                                                    input int depth);
        logic [GRP_W:0] g;
        g = {1'b0, grp};
        for (int i = 0; i < 3; i++) begin
            if (int'(g) >= depth) begin
                g = g - (GRP_W+1)'(depth);
            end
        end
        return g[GRP_W-1:0];
    endfunction

endpackage

FILE: rtl/pcrr_ifs.sv
// Handshake channel interfaces: request in, result out, register write.
// Depends on pcrr_pkg for field widths.
interface pcrr_req_if import pcrr_pkg::*;;
    logic                valid;
    logic                ready;
    logic                command;
    logic [OP_W-1:0]     op_class;
    logic [GRP_W-1:0]    group;
    logic [HINT_W-1:0]   pin_hint;
    logic [WORKER_W-1:0] done_worker;

    modport source (output valid, command, op_class, group, pin_hint, done_worker,
                    input ready);
    modport sink   (input valid, command, op_class, group, pin_hint, done_worker,
                    output ready);
endinterface

interface pcrr_rsp_if import pcrr_pkg::*;;
    logic                valid;
    logic                ready;
    logic [WORKER_W-1:0] worker;
    logic                redirected;
    logic [PEND_W-1:0]   pending;

    modport source (output valid, worker, redirected, pending, input ready);
    modport sink   (input valid, worker, redirected, pending, output ready);
endinterface

interface pcrr_cfg_if import pcrr_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/pcrr_ptr_table.sv
// Round-robin pointers, one per pool and scheduler group, with wrap logic.
// Depends on pcrr_pkg.
module pcrr_ptr_table import pcrr_pkg::*; #(
    parameter int MAX_GROUPS = DEF_MAX_GROUPS,
    localparam int GW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  t_ptr_ctl         i_ctl,
    input  logic [GW-1:0]    i_gi,
    output logic [CNT_W-1:0] o_ptr
);

    logic [CNT_W-1:0] r_ptr [NUM_POOLS][MAX_GROUPS];
    logic [CNT_W-1:0] limit;
    logic [CNT_W-1:0] inc;
    logic [CNT_W-1:0] n_ptr;

    assign o_ptr = r_ptr[i_ctl.pool][i_gi];

    always_comb begin
        case (i_ctl.pool)
            POOL_STAT: limit = i_cfg.stat_workers;
            POOL_GET:  limit = i_cfg.get_workers;
            POOL_PUT:  limit = i_cfg.put_workers;
            POOL_VAL:  limit = i_cfg.validate_workers;
            // keep the last update worker for pinned requests
            POOL_UPD:  limit = (i_cfg.update_workers != '0) ?
                               i_cfg.update_workers - 1'b1 : '0;
            default:   limit = '0;
        endcase
        inc   = o_ptr + 1'b1;
        n_ptr = (inc >= limit) ? '0 : inc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_POOLS; p++) begin
                for (int g = 0; g < MAX_GROUPS; g++) begin
                    r_ptr[p][g] <= '0;
                end
            end
        end else if (i_ctl.adv) begin
            r_ptr[i_ctl.pool][i_gi] <= n_ptr;
        end
    end

endmodule

FILE: rtl/pcrr_pend_store.sv
// Pending-count memory: one write and one registered read port, plus the
// clearing pass that zeroes every entry after reset. Depends on pcrr_pkg.
module pcrr_pend_store import pcrr_pkg::*; #(
    parameter int MAX_WORKERS = DEF_MAX_WORKERS,
    localparam int AW = $clog2(MAX_WORKERS)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    output logic              o_clearing,
    input  logic              i_rd_en,
    input  logic [AW-1:0]     i_rd_addr,
    output logic [PEND_W-1:0] o_rd_data,
    input  logic              i_wr_en,
    input  logic [AW-1:0]     i_wr_addr,
    input  logic [PEND_W-1:0] i_wr_data
);

    logic [PEND_W-1:0] mem [MAX_WORKERS];
    logic              r_clearing;
    logic [AW-1:0]     r_clr_addr;
    logic [PEND_W-1:0] r_rd_data;

    assign o_clearing = r_clearing;
    assign o_rd_data  = r_rd_data;

    // sweep one entry per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(MAX_WORKERS - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

endmodule

FILE: rtl/per_class_round_robin_dispatch.sv
// Top level of the per-class round-robin dispatcher: configuration
// registers, item sequencer, index arithmetic and result register.
// Depends on pcrr_pkg, pcrr_ifs, pcrr_ptr_table and pcrr_pend_store.
//
// One item is handled at a time. A dispatch transfer passes five stages
// (capture, pool offset and group base with pointer advance, index add and
// range check, memory read, write-back). A done transfer passes three
// stages (capture, read, write-back). Both end in the read-modify-write of
// the pending-count memory, which holds one count per worker. The input is
// ready again in the cycle after the result is loaded, so a result still
// waiting on the output does not stop the next item from being taken; only
// its own write-back waits for the output register to drain. After reset a
// clearing pass zeroes the pending memory, during which no request is
// taken; register writes are taken at any time and should only be issued
// while the block is idle. An undefined op class, or an index at or beyond
// the configured worker total or beyond the memory, is steered to worker 0
// with redirected set, and both count directions saturate.
module per_class_round_robin_dispatch import pcrr_pkg::*; #(
    parameter int MAX_GROUPS  = DEF_MAX_GROUPS,
    parameter int MAX_WORKERS = DEF_MAX_WORKERS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pcrr_req_if.sink   i_req,
    pcrr_rsp_if.source o_rsp,
    pcrr_cfg_if.sink   i_cfg
);

    localparam int GW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int AW = $clog2(MAX_WORKERS);

    // ---------------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------------
    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stat_workers     <= RST_STAT;
            r_cfg.get_workers      <= RST_GET;
            r_cfg.put_workers      <= RST_PUT;
            r_cfg.validate_workers <= RST_VAL;
            r_cfg.update_workers   <= RST_UPD;
            r_cfg.scheduler_count  <= RST_SCHED;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_STAT:  r_cfg.stat_workers     <= i_cfg.data;
                CFG_GET:   r_cfg.get_workers      <= i_cfg.data;
                CFG_PUT:   r_cfg.put_workers      <= i_cfg.data;
                CFG_VAL:   r_cfg.validate_workers <= i_cfg.data;
                CFG_UPD:   r_cfg.update_workers   <= i_cfg.data;
                CFG_SCHED: r_cfg.scheduler_count  <= i_cfg.data[SCHED_W-1:0];
                default:   ; // drop writes beyond the register list
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    t_state r_state, n_state;
    logic   clearing;
    logic   req_ready;
    logic   accept;
    logic   wb_go;
    logic   rd_en;
    logic   wr_en;

    // captured item
    logic                r_cmd;
    logic [OP_W-1:0]     r_op;
    logic [GRP_W-1:0]    r_grp;
    logic [HINT_W-1:0]   r_hint;

    // datapath registers
    logic [TID_W-1:0]    r_base;
    logic [TID_W-1:0]    r_total;
    logic [TID_W-1:0]    r_off;
    logic                r_valid_op;
    logic [TID_W-1:0]    r_tid;
    logic                r_redir;
    logic                r_skip;

    // result register
    logic                r_out_valid;
    logic [WORKER_W-1:0] r_out_worker;
    logic                r_out_redir;
    logic [PEND_W-1:0]   r_out_pending;

    assign accept = i_req.valid && req_ready;
    // write-back proceeds once the result register is free or draining
    assign wb_go  = !r_out_valid || o_rsp.ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = (i_req.command == CMD_DONE) ? ST_READ : ST_CALC;
                end
            end
            ST_CALC: n_state = ST_ADDR;
            ST_ADDR: n_state = ST_READ;
            ST_READ: n_state = ST_WB;
            ST_WB: begin
                if (wb_go) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        req_ready = 1'b0;
        rd_en     = 1'b0;
        wr_en     = 1'b0;
        case (r_state)
            ST_IDLE: req_ready = !clearing;
            ST_READ: rd_en     = 1'b1;
            ST_WB:   wr_en     = wb_go && !r_skip;
            default: ;
        endcase
    end

    assign i_req.ready = req_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------------------------------------------------------------
    // Pool offset, group base and pointer control (ST_CALC)
    // ---------------------------------------------------------------------
    t_ptr_ctl         ptr_ctl;
    logic [CNT_W-1:0] ptr;
    logic [GW-1:0]    gi;
    logic             pinned;
    logic [TID_W-1:0] per;
    logic [TID_W-1:0] get_start;
    logic [TID_W-1:0] put_start;
    logic [TID_W-1:0] val_start;
    logic [TID_W-1:0] upd_start;
    logic [TID_W-1:0] n_off;
    logic             n_valid_op;
    logic             use_ptr;

    assign gi     = GW'(grp_index(r_grp, MAX_GROUPS));
    assign pinned = (r_hint == HINT_W'(1));

    always_comb begin
        get_start = TID_W'(r_cfg.stat_workers);
        put_start = get_start + TID_W'(r_cfg.get_workers);
        val_start = put_start + TID_W'(r_cfg.put_workers);
        upd_start = val_start + TID_W'(r_cfg.validate_workers);
        per       = upd_start + TID_W'(r_cfg.update_workers);
    end

    always_comb begin
        ptr_ctl.pool = POOL_STAT;
        use_ptr      = 1'b0;
        n_off        = '0;
        n_valid_op   = 1'b1;
        case (r_op)
            OP_READ: begin
                ptr_ctl.pool = POOL_GET;
                if (pinned) begin
                    n_off = put_start - 1'b1;
                end else if (r_hint != '0) begin
                    n_off = get_start + TID_W'(r_hint);
                end else begin
                    n_off   = get_start + TID_W'(ptr);
                    use_ptr = 1'b1;
                end
            end
            OP_WRITE: begin
                ptr_ctl.pool = POOL_PUT;
                n_off        = put_start + TID_W'(ptr);
                use_ptr      = 1'b1;
            end
            OP_STAT, OP_DELETE: begin
                ptr_ctl.pool = POOL_STAT;
                n_off        = TID_W'(ptr);
                use_ptr      = 1'b1;
            end
            OP_UPDATE: begin
                // the update pointer advances even when pinned
                ptr_ctl.pool = POOL_UPD;
                n_off        = pinned ? per - 1'b1 : upd_start + TID_W'(ptr);
                use_ptr      = 1'b1;
            end
            OP_VALIDATE: begin
                ptr_ctl.pool = POOL_VAL;
                n_off        = val_start + TID_W'(ptr);
                use_ptr      = 1'b1;
            end
            default: n_valid_op = 1'b0;
        endcase
        ptr_ctl.adv = (r_state == ST_CALC) && use_ptr;
    end

    pcrr_ptr_table #(
        .MAX_GROUPS(MAX_GROUPS)
    ) u_ptr_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_ctl   (ptr_ctl),
        .i_gi    (gi),
        .o_ptr   (ptr)
    );

    // ---------------------------------------------------------------------
    // Index and range check (ST_ADDR)
    // ---------------------------------------------------------------------
    logic [TID_W-1:0] tid_sum;
    logic             out_of_range;

    assign tid_sum      = r_base + r_off;
    // modular sum: a pinned index below an empty first group wraps high
    assign out_of_range = !r_valid_op || (tid_sum >= r_total) ||
                          (tid_sum >= TID_W'(MAX_WORKERS));

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    r_cmd  <= i_req.command;
                    r_op   <= i_req.op_class;
                    r_grp  <= i_req.group;
                    r_hint <= i_req.pin_hint;
                    // done items go straight to the read
                    r_tid   <= TID_W'(i_req.done_worker);
                    r_redir <= 1'b0;
                    r_skip  <= (TID_W'(i_req.done_worker) >= TID_W'(MAX_WORKERS));
                end
            end
            ST_CALC: begin
                r_base     <= TID_W'(r_grp * per);
                r_total    <= TID_W'(r_cfg.scheduler_count * per);
                r_off      <= n_off;
                r_valid_op <= n_valid_op;
            end
            ST_ADDR: begin
                r_tid   <= out_of_range ? '0 : tid_sum;
                r_redir <= out_of_range;
                r_skip  <= 1'b0;
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------------
    // Pending memory and saturating update (ST_READ, ST_WB)
    // ---------------------------------------------------------------------
    logic [PEND_W-1:0] rd_data;
    logic [PEND_W-1:0] n_pend;

    pcrr_pend_store #(
        .MAX_WORKERS(MAX_WORKERS)
    ) u_pend_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .o_clearing (clearing),
        .i_rd_en    (rd_en),
        .i_rd_addr  (r_tid[AW-1:0]),
        .o_rd_data  (rd_data),
        .i_wr_en    (wr_en),
        .i_wr_addr  (r_tid[AW-1:0]),
        .i_wr_data  (n_pend)
    );

    always_comb begin
        if (r_cmd == CMD_DONE) begin
            n_pend = (rd_data != '0) ? rd_data - 1'b1 : rd_data;
        end else begin
            n_pend = (rd_data != '1) ? rd_data + 1'b1 : rd_data;
        end
    end

    // ---------------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_WB && wb_go) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_WB && wb_go) begin
            r_out_worker  <= r_tid[WORKER_W-1:0];
            r_out_redir   <= r_redir;
            r_out_pending <= r_skip ? '0 : n_pend;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.worker     = r_out_worker;
    assign o_rsp.redirected = r_out_redir;
    assign o_rsp.pending    = r_out_pending;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_redir_to_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.redirected |-> o_rsp.worker == '0)
        else $error("redirected result does not name worker 0");

    a_no_take_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clearing |-> !i_req.ready)
        else $error("request taken during pending memory clear");

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_state != ST_IDLE)
        else $error("sequencer stayed idle after a transfer");

    a_wb_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (!r_out_valid || o_rsp.ready) && !clearing)
        else $error("write-back while the result register is held");

endmodule

FILE: tb/tb_top.sv
// Self-checking bench for per_class_round_robin_dispatch: a table of opening cases, then
// random traffic over several register settings, checked against an in-bench predictor.
// Depends on pcrr_pkg, the pcrr_ifs channel interfaces and the dispatcher RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import pcrr_pkg::*;

    localparam int PHASE_ITEMS     = 222;    // random transfers per register setting
    localparam int HOLD_OFF_AFTER  = 150;    // results taken before the long hold-off
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int SETTLE_CYCLES   = 8;
    localparam int TAIL_CYCLES     = 20;
    localparam int TAIL_LIMIT      = 20000;
    localparam int MAX_PRINTED     = 40;
    localparam int STORE_DEPTH     = DEF_MAX_WORKERS;
    localparam int RECENT_DEPTH    = 32;
    localparam logic [PEND_W-1:0] PEND_TOP = '1;

    // Op codes with no pool behind them; the block must steer these to worker 0.
    localparam logic [OP_W-1:0] OP_UNDEF_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_UNDEF_HI = 3'd7;

    typedef struct {
        t_cmd                command;
        logic [OP_W-1:0]     op;
        logic [GRP_W-1:0]    grp;
        logic [HINT_W-1:0]   hint;
        logic [WORKER_W-1:0] done;
    } t_req_item;

    typedef struct {
        logic [WORKER_W-1:0] worker;
        logic                redirected;
        logic [PEND_W-1:0]   pending;
    } t_rsp_item;

    // One row of the opening table; typed rows carry a result read straight off the spec.
    typedef struct {
        t_req_item item;
        bit        typed;
        t_rsp_item want;
    } t_plan_row;

    typedef struct {
        logic [CNT_W-1:0]   stat_n;
        logic [CNT_W-1:0]   get_n;
        logic [CNT_W-1:0]   put_n;
        logic [CNT_W-1:0]   val_n;
        logic [CNT_W-1:0]   upd_n;
        logic [SCHED_W-1:0] groups;
    } t_setting;

    // ------------------------------------------------------------------
    // Clock, reset and channels
    // ------------------------------------------------------------------
    logic i_clk = 1'b0;
    logic i_rst_n;

    always #1 i_clk = ~i_clk;

    pcrr_req_if req_ch ();
    pcrr_rsp_if rsp_ch ();
    pcrr_cfg_if cfg_ch ();

    per_class_round_robin_dispatch DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .i_cfg   (cfg_ch)
    );

    // ------------------------------------------------------------------
    // Mirror of the block: register copies, round-robin pointers per group
    // and pool, and the per-worker pending counts.
    // ------------------------------------------------------------------
    int unsigned      n_stat, n_get, n_put, n_val, n_upd, n_groups;
    logic [CNT_W-1:0] rr_stat [DEF_MAX_GROUPS];
    logic [CNT_W-1:0] rr_get  [DEF_MAX_GROUPS];
    logic [CNT_W-1:0] rr_put  [DEF_MAX_GROUPS];
    logic [CNT_W-1:0] rr_val  [DEF_MAX_GROUPS];
    logic [CNT_W-1:0] rr_upd  [DEF_MAX_GROUPS];
    logic [PEND_W-1:0] pending_mirror [STORE_DEPTH];

    t_rsp_item due_results [$];   // results owed by the block, oldest first
    int        recent_workers [$];
    t_rsp_item no_want = '{default: '0};

    int mismatches       = 0;
    int results_checked  = 0;
    int items_sent       = 0;
    int settings_loaded  = 0;

    // Step a round-robin pointer; back to 0 once it reaches the limit.
    function automatic logic [CNT_W-1:0] next_slot(input logic [CNT_W-1:0] p,
                                                   input int unsigned limit);
        int unsigned n;
        n = (int'(p) + 1) & 8'hFF;
        return (n >= limit) ? '0 : n[CNT_W-1:0];
    endfunction

    // Work out the result of one accepted transfer and advance the mirror state.
    function automatic t_rsp_item predict_dispatch(input t_req_item it);
        t_rsp_item   r;
        int unsigned per, total, base, get_at, put_at, val_at, upd_at, upd_end, tid;
        int          gi;
        bit          known_op;

        if (it.command == CMD_DONE) begin
            if (pending_mirror[it.done] != '0)
                pending_mirror[it.done]--;
            r.worker     = it.done;
            r.redirected = 1'b0;
            r.pending    = pending_mirror[it.done];
            return r;
        end

        per      = n_stat + n_get + n_put + n_val + n_upd;
        total    = n_groups * per;
        base     = it.grp * per;
        get_at   = n_stat;
        put_at   = get_at + n_get;
        val_at   = put_at + n_put;
        upd_at   = val_at + n_val;
        upd_end  = upd_at + n_upd;
        gi       = int'(it.grp) % DEF_MAX_GROUPS;
        tid      = 0;
        known_op = 1'b1;

        case (it.op)
            OP_READ: begin
                if (it.hint == 8'd1) begin
                    tid = base + put_at - 1;
                end else if (it.hint > 8'd1) begin
                    tid = base + get_at + it.hint;
                end else begin
                    tid = base + get_at + rr_get[gi];
                    rr_get[gi] = next_slot(rr_get[gi], n_get);
                end
            end
            OP_WRITE: begin
                tid = base + put_at + rr_put[gi];
                rr_put[gi] = next_slot(rr_put[gi], n_put);
            end
            OP_STAT, OP_DELETE: begin
                tid = base + rr_stat[gi];
                rr_stat[gi] = next_slot(rr_stat[gi], n_stat);
            end
            OP_UPDATE: begin
                // Pinned or not, the update pointer moves, and it wraps one short.
                if (it.hint == 8'd1)
                    tid = base + upd_end - 1;
                else
                    tid = base + upd_at + rr_upd[gi];
                rr_upd[gi] = next_slot(rr_upd[gi], (n_upd > 0) ? n_upd - 1 : 0);
            end
            OP_VALIDATE: begin
                tid = base + val_at + rr_val[gi];
                rr_val[gi] = next_slot(rr_val[gi], n_val);
            end
            default: known_op = 1'b0;
        endcase

        // An empty pool wraps the unsigned index round to a huge value; caught here too.
        r.redirected = 1'b0;
        if (!known_op || tid >= total || tid >= STORE_DEPTH) begin
            tid          = 0;
            r.redirected = 1'b1;
        end
        if (pending_mirror[tid] != PEND_TOP)
            pending_mirror[tid]++;
        r.worker  = tid[WORKER_W-1:0];
        r.pending = pending_mirror[tid];
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        if (mismatches < MAX_PRINTED)
            $display("MISMATCH %s: got %0d, expected %0d (result %0d)",
                     what, got, want, results_checked);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Result checker: compare each transfer on the output with the oldest
    // expectation, field by field.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_rsp_item want;
        if (i_rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (due_results.size() == 0) begin
                flag_mismatch("result with nothing outstanding", int'(rsp_ch.worker), -1);
            end else begin
                want = due_results.pop_front();
                if (rsp_ch.worker !== want.worker)
                    flag_mismatch("worker", int'(rsp_ch.worker), int'(want.worker));
                if (rsp_ch.redirected !== want.redirected)
                    flag_mismatch("redirected", int'(rsp_ch.redirected), int'(want.redirected));
                if (rsp_ch.pending !== want.pending)
                    flag_mismatch("pending", int'(rsp_ch.pending), int'(want.pending));
            end
            results_checked++;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: open stretches of random length broken by short stalls,
    // plus one long hold-off so the block backs up and stalls its input.
    // ------------------------------------------------------------------
    initial begin : receiver
        int open_left;
        int hold_left;
        int taken;
        bit pressed;
        open_left = 0;
        hold_left = 0;
        taken     = 0;
        pressed   = 1'b0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
                taken++;
            if (!pressed && taken >= HOLD_OFF_AFTER) begin
                pressed   = 1'b1;
                hold_left = HOLD_OFF_CYCLES;
                open_left = 0;
            end
            if (hold_left == 0 && open_left == 0) begin
                // Now and then a long open stretch, so some phases see no stalls at all.
                open_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                         : $urandom_range(1, 20);
                hold_left = $urandom_range(0, 5);
            end
            if (hold_left > 0) begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                rsp_ch.ready <= 1'b1;
                open_left--;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one request and hold it until the transfer; valid stays high on
    // return so a following request goes out without a bubble.
    task automatic send_item(input t_req_item it, input bit typed, input t_rsp_item want);
        t_rsp_item guess;
        req_ch.valid       <= 1'b1;
        req_ch.command     <= it.command;
        req_ch.op_class    <= it.op;
        req_ch.group       <= it.grp;
        req_ch.pin_hint    <= it.hint;
        req_ch.done_worker <= it.done;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        guess = predict_dispatch(it);
        due_results.push_back(typed ? want : guess);
        if (it.command == CMD_DISPATCH) begin
            recent_workers.push_back(int'(guess.worker));
            if (recent_workers.size() > RECENT_DEPTH)
                void'(recent_workers.pop_front());
        end
        items_sent++;
    endtask

    // Random request: mostly dispatches to live groups with a fair share of
    // pinning hints; done items mostly hit workers that were handed work lately.
    function automatic t_req_item gen_item();
        t_req_item it;
        int        pick;
        int        grp_top;
        it.command = ($urandom_range(0, 3) == 0) ? CMD_DONE : CMD_DISPATCH;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            it.op = OP_UNDEF_LO;
        else if (pick < 6)
            it.op = OP_UNDEF_HI;
        else
            it.op = OP_W'($urandom_range(int'(OP_READ), int'(OP_VALIDATE)));
        grp_top = (n_groups > DEF_MAX_GROUPS) ? DEF_MAX_GROUPS - 1 : int'(n_groups) - 1;
        if ($urandom_range(0, 9) == 0)
            it.grp = GRP_W'($urandom_range(0, 3));
        else
            it.grp = GRP_W'($urandom_range(0, grp_top));
        pick = $urandom_range(0, 9);
        if (pick < 5)
            it.hint = '0;
        else if (pick < 7)
            it.hint = 8'd1;
        else
            it.hint = HINT_W'($urandom_range(2, 255));
        if (recent_workers.size() != 0 && $urandom_range(0, 3) != 0)
            it.done = WORKER_W'(recent_workers[$urandom_range(0, recent_workers.size() - 1)]);
        else
            it.done = WORKER_W'($urandom_range(0, 1023));
        return it;
    endfunction

    // Random traffic in bursts with random gaps; max_gap 0 sends back to back.
    task automatic run_random(input int count, input int max_gap);
        int left;
        int burst;
        int gap;
        left = count;
        while (left > 0) begin
            burst = $urandom_range(1, 24);
            if (burst > left)
                burst = left;
            repeat (burst) send_item(gen_item(), 1'b0, no_want);
            left -= burst;
            gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
            if (gap > 0) begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        req_ch.valid <= 1'b0;
    endtask

    // Write one register and mirror it; valid stays high for the next write.
    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        case (idx)
            CFG_STAT:  n_stat   = value;
            CFG_GET:   n_get    = value;
            CFG_PUT:   n_put    = value;
            CFG_VAL:   n_val    = value;
            CFG_UPD:   n_upd    = value;
            CFG_SCHED: n_groups = value[SCHED_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_setting(input t_setting s);
        write_reg(CFG_STAT,  s.stat_n);
        write_reg(CFG_GET,   s.get_n);
        write_reg(CFG_PUT,   s.put_n);
        write_reg(CFG_VAL,   s.val_n);
        write_reg(CFG_UPD,   s.upd_n);
        write_reg(CFG_SCHED, CFG_DATA_W'(s.groups));
        cfg_ch.valid <= 1'b0;
        settings_loaded++;
    endtask

    // Hold until every owed result has come back, then let the pipe empty.
    task automatic settle();
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Opening cases under the reset register values: group size 138, two
    // groups, so 276 valid workers; pools start at 0, 32, 112, 122 and 130.
    // ------------------------------------------------------------------
    t_plan_row opening_plan [23] = '{
        // done item on an idle worker stays at zero
        '{'{CMD_DONE,     OP_READ,     2'd0, 8'd0,   10'd5},    1'b1, '{10'd5,   1'b0, 16'd0}},
        '{'{CMD_DISPATCH, OP_READ,     2'd0, 8'd0,   10'd0},    1'b1, '{10'd32,  1'b0, 16'd1}},
        // read pinned to the last get worker
        '{'{CMD_DISPATCH, OP_READ,     2'd0, 8'd1,   10'd0},    1'b1, '{10'd111, 1'b0, 16'd1}},
        // explicit get offset past the valid total goes to worker 0
        '{'{CMD_DISPATCH, OP_READ,     2'd0, 8'd255, 10'd0},    1'b1, '{10'd0,   1'b1, 16'd1}},
        '{'{CMD_DISPATCH, OP_READ,     2'd1, 8'd2,   10'd0},    1'b0, '{10'd0,   1'b0, 16'd0}},
        // writes use the put pointer
        '{'{CMD_DISPATCH, OP_WRITE,    2'd0, 8'd0,   10'd0},    1'b1, '{10'd112, 1'b0, 16'd1}},
        '{'{CMD_DISPATCH, OP_STAT,     2'd0, 8'd0,   10'd0},    1'b1, '{10'd0,   1'b0, 16'd2}},
        '{'{CMD_DISPATCH, OP_DELETE,   2'd0, 8'd0,   10'd0},    1'b1, '{10'd1,   1'b0, 16'd1}},
        '{'{CMD_DISPATCH, OP_UPDATE,   2'd0, 8'd0,   10'd0},    1'b1, '{10'd130, 1'b0, 16'd1}},
        // update pinned to the reserved last update worker
        '{'{CMD_DISPATCH, OP_UPDATE,   2'd0, 8'd1,   10'd0},    1'b1, '{10'd137, 1'b0, 16'd1}},
        '{'{CMD_DISPATCH, OP_VALIDATE, 2'd1, 8'd0,   10'd0},    1'b1, '{10'd260, 1'b0, 16'd1}},
        // undefined op classes land on worker 0
        '{'{CMD_DISPATCH, OP_UNDEF_LO, 2'd0, 8'd0,   10'd0},    1'b1, '{10'd0,   1'b1, 16'd3}},
        '{'{CMD_DISPATCH, OP_UNDEF_HI, 2'd3, 8'd255, 10'd1023}, 1'b1, '{10'd0,   1'b1, 16'd4}},
        // groups at or above the active count fall outside the total
        '{'{CMD_DISPATCH, OP_STAT,     2'd3, 8'd0,   10'd0},    1'b1, '{10'd0,   1'b1, 16'd5}},
        '{'{CMD_DISPATCH, OP_STAT,     2'd2, 8'd0,   10'd0},    1'b0, '{10'd0,   1'b0, 16'd0}},
        '{'{CMD_DONE,     OP_READ,     2'd0, 8'd0,   10'd0},    1'b1, '{10'd0,   1'b0, 16'd5}},
        // done item ignores its other fields; top worker index is echoed
        '{'{CMD_DONE,     OP_UNDEF_HI, 2'd3, 8'd255, 10'd1023}, 1'b1, '{10'd1023, 1'b0, 16'd0}},
        '{'{CMD_DONE,     OP_READ,     2'd0, 8'd0,   10'd32},   1'b0, '{10'd0,   1'b0, 16'd0}},
        '{'{CMD_DONE,     OP_READ,     2'd0, 8'd0,   10'd32},   1'b0, '{10'd0,   1'b0, 16'd0}},
        '{'{CMD_DISPATCH, OP_WRITE,    2'd1, 8'd255, 10'd0},    1'b0, '{10'd0,   1'b0, 16'd0}},
        '{'{CMD_DISPATCH, OP_UPDATE,   2'd1, 8'd255, 10'd0},    1'b0, '{10'd0,   1'b0, 16'd0}},
        '{'{CMD_DISPATCH, OP_READ,     2'd3, 8'd1,   10'd0},    1'b0, '{10'd0,   1'b0, 16'd0}},
        '{'{CMD_DISPATCH, OP_VALIDATE, 2'd0, 8'd0,   10'd1023}, 1'b0, '{10'd0,   1'b0, 16'd0}}
    };

    // Fixed settings: smallest pools, largest pools (group size beyond the
    // store), small pools after large ones (pointers left high must wrap),
    // empty get and update pools, and mid-sized pools in four groups.
    t_setting fixed_settings [5] = '{
        '{8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   3'd1},
        '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 3'd4},
        '{8'd3,   8'd6,   8'd2,   8'd4,   8'd3,   3'd4},
        '{8'd5,   8'd0,   8'd4,   8'd2,   8'd0,   3'd3},
        '{8'd40,  8'd60,  8'd30,  8'd20,  8'd10,  3'd4}
    };

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_setting  pick;
        int        wait_n;

        i_rst_n            <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.command     <= CMD_DISPATCH;
        req_ch.op_class    <= OP_READ;
        req_ch.group       <= '0;
        req_ch.pin_hint    <= '0;
        req_ch.done_worker <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= CFG_STAT;
        cfg_ch.data        <= '0;

        // Mirror starts from the reset values.
        n_stat   = RST_STAT;
        n_get    = RST_GET;
        n_put    = RST_PUT;
        n_val    = RST_VAL;
        n_upd    = RST_UPD;
        n_groups = RST_SCHED;
        for (int g = 0; g < DEF_MAX_GROUPS; g++) begin
            rr_stat[g] = '0;
            rr_get[g]  = '0;
            rr_put[g]  = '0;
            rr_val[g]  = '0;
            rr_upd[g]  = '0;
        end
        for (int w = 0; w < STORE_DEPTH; w++)
            pending_mirror[w] = '0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Opening table; the first transfer waits out the clearing pass on ready.
        foreach (opening_plan[r])
            send_item(opening_plan[r].item, opening_plan[r].typed, opening_plan[r].want);
        req_ch.valid <= 1'b0;

        // Random traffic under the reset values, then under each new setting.
        settle();
        run_random(PHASE_ITEMS, 7);
        for (int ph = 0; ph < 7; ph++) begin
            settle();
            if (ph < 5) begin
                pick = fixed_settings[ph];
            end else begin
                pick.stat_n = CNT_W'($urandom_range(1, 12));
                pick.get_n  = CNT_W'($urandom_range(1, 12));
                pick.put_n  = CNT_W'($urandom_range(1, 12));
                pick.val_n  = CNT_W'($urandom_range(1, 12));
                pick.upd_n  = CNT_W'($urandom_range(1, 12));
                pick.groups = SCHED_W'($urandom_range(1, 4));
            end
            load_setting(pick);
            run_random(PHASE_ITEMS, (ph % 3 == 1) ? 0 : 7);
        end

        // Drain, bounded, then let the pipe empty.
        for (wait_n = 0; wait_n < TAIL_LIMIT && due_results.size() != 0; wait_n++)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (due_results.size() != 0)
            flag_mismatch("results never delivered", 0, due_results.size());

        $display("Covered %0d requests under %0d register settings plus the reset values,",
                 items_sent, settings_loaded);
        $display("including a %0d-cycle output hold-off and the zero floor of the counts; %0d results",
                 HOLD_OFF_CYCLES, results_checked);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin : watchdog
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

FILE: files.f
rtl/pcrr_pkg.sv
rtl/pcrr_ifs.sv
rtl/pcrr_ptr_table.sv
rtl/pcrr_pend_store.sv
rtl/per_class_round_robin_dispatch.sv
tb/tb_top.sv
